// ===== src/pssc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pen stroke shape classifier package
// Payload structs, shape codes and the command word between front and back.
// ----------------------------------------------------------------------------
package pssc_pkg;

  localparam int CoordW = 16;
  localparam int TolW = 16;

  typedef enum logic [1:0] {
    SHAPE_NONE    = 2'd0,
    SHAPE_LINE    = 2'd1,
    SHAPE_ELLIPSE = 2'd2
  } shape_t;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     last_point;
  } point_in_t;

  typedef struct packed {
    logic [1:0]               shape_kind;
    logic                     buffer_overflow;
    logic signed [CoordW-1:0] box_left;
    logic signed [CoordW-1:0] box_top;
    logic signed [CoordW-1:0] box_right;
    logic signed [CoordW-1:0] box_bottom;
    logic signed [CoordW-1:0] line_start_x;
    logic signed [CoordW-1:0] line_start_y;
    logic signed [CoordW-1:0] line_end_x;
    logic signed [CoordW-1:0] line_end_y;
  } shape_out_t;

  // Stroke summary handed from the front part to the back part.
  typedef struct packed {
    logic                     overflow;
    logic                     short_stroke;
    logic signed [CoordW-1:0] box_l;
    logic signed [CoordW-1:0] box_t;
    logic signed [CoordW-1:0] box_r;
    logic signed [CoordW-1:0] box_b;
  } stroke_cmd_t;

endpackage

// ===== src/pen_stroke_shape_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pen stroke shape classifier
// Stores stroke points, tracks the bounding box and classifies the stroke as
// none, line or ellipse when its last point arrives.
//
//   channel  signals                          transfer when
//   point    point_valid point_stall point     valid && !stall
//   shape    shape_valid shape_stall shape     valid && !stall
//   config   line_tolerance_we line_tolerance_wdata   we
//
// An accepted point is written into the store while it has room. A closing
// point queues the stroke for the back end, which reads its points, once it
// leaves the queue, through the store's single read port; a short or
// overflowing stroke skips the reads and is reported as none. The front end
// stalls while a closed stroke waits in the one-entry queue and while the back
// end reads the store. Reset is synchronous and clears the box, count and tolerance (to 6554).
// ----------------------------------------------------------------------------
module pen_stroke_shape_classifier #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          point_valid,
  output logic                          point_stall,
  input  pssc_pkg::point_in_t           point,
  output logic                          shape_valid,
  input  logic                          shape_stall,
  output pssc_pkg::shape_out_t          shape,
  input  logic                          line_tolerance_we,
  input  logic [pssc_pkg::TolW-1:0]     line_tolerance_wdata
);

  localparam int COORD_BITS = pssc_pkg::CoordW;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int AW = $clog2(MAX_POINTS);

  logic [pssc_pkg::TolW-1:0] tol;
  logic [2*COORD_BITS-1:0] store [MAX_POINTS];
  logic [2*COORD_BITS-1:0] rd_data;
  logic wr_en, rd_en, f_valid, q_full, pop, scan_busy;
  logic [AW-1:0] wr_addr, rd_addr;
  pssc_pkg::stroke_cmd_t f_cmd, q_cmd;
  logic [CW-1:0] f_count, q_count;

  always_ff @(posedge clk) begin
    if (rst) tol <= pssc_pkg::TolW'(6554);
    else if (line_tolerance_we) tol <= line_tolerance_wdata;
  end

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= {COORD_BITS'(point.point_x), COORD_BITS'(point.point_y)};
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_full <= 1'b0;
    end else if (f_valid) begin
      q_full <= 1'b1;
      q_cmd <= f_cmd;
      q_count <= f_count;
    end else if (pop) begin
      q_full <= 1'b0;
    end
  end

  pssc_front #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(point_valid), .in_stall(point_stall),
    .px(COORD_BITS'(point.point_x)), .py(COORD_BITS'(point.point_y)),
    .last(point.last_point),
    .wr_en(wr_en), .wr_addr(wr_addr),
    .cmd_valid(f_valid), .cmd(f_cmd), .cmd_count(f_count),
    .cmd_full(q_full || scan_busy)
  );

  pssc_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
    .clk(clk), .rst(rst), .tol(tol),
    .cmd_valid(q_full), .cmd(q_cmd), .cmd_count(q_count), .cmd_pop(pop),
    .scan_busy(scan_busy),
    .rd_en(rd_en), .rd_addr(rd_addr),
    .rd_x(rd_data[2*COORD_BITS-1:COORD_BITS]), .rd_y(rd_data[COORD_BITS-1:0]),
    .out_valid(shape_valid), .out_stall(shape_stall), .out_data(shape)
  );

endmodule

// ===== src/pssc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stroke front end
// Writes points into the store, tracks the bounding box and count, and hands
// a stroke summary to the back end when the last point is transferred.
// ----------------------------------------------------------------------------
module pssc_front #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16,
  parameter int CW = $clog2(MAX_POINTS + 1),
  parameter int AW = $clog2(MAX_POINTS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic                         last,
  output logic                         wr_en,
  output logic [AW-1:0]                wr_addr,
  output logic                         cmd_valid,
  output pssc_pkg::stroke_cmd_t        cmd,
  output logic [CW-1:0]                cmd_count,
  input  logic                         cmd_full
);

  logic [CW-1:0] count;
  logic signed [COORD_BITS-1:0] bl, bt, br, bb;
  logic ovf;
  logic take, room, first;
  logic signed [COORD_BITS-1:0] nl, nt, nr, nb;

  assign in_stall = cmd_full;
  assign take = in_valid && !cmd_full;
  assign room = count < CW'(MAX_POINTS);
  assign first = count == '0;
  assign wr_en = take && room;
  assign wr_addr = count[AW-1:0];

  always_comb begin
    nl = bl; nt = bt; nr = br; nb = bb;
    if (room) begin
      if (first || px < bl) nl = px;
      if (first || px > br) nr = px;
      if (first || py < bt) nt = py;
      if (first || py > bb) nb = py;
    end
  end

  assign cmd_valid = take && last;
  assign cmd_count = room ? count + CW'(1) : count;
  assign cmd.overflow = ovf || !room;
  assign cmd.short_stroke = cmd_count < CW'(5);
  assign cmd.box_l = pssc_pkg::CoordW'(nl);
  assign cmd.box_t = pssc_pkg::CoordW'(nt);
  assign cmd.box_r = pssc_pkg::CoordW'(nr);
  assign cmd.box_b = pssc_pkg::CoordW'(nb);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; ovf <= 1'b0;
      bl <= '0; bt <= '0; br <= '0; bb <= '0;
    end else if (take) begin
      if (last) begin
        count <= '0; ovf <= 1'b0;
        bl <= '0; bt <= '0; br <= '0; bb <= '0;
      end else begin
        if (room) count <= count + CW'(1);
        else ovf <= 1'b1;
        bl <= nl; bt <= nt; br <= nr; bb <= nb;
      end
    end
  end

endmodule

// ===== src/pssc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stroke back end
// Scans the stored points of a closed stroke for the peak chord deviation,
// runs the line and ellipse tests and holds the result in an output register.
// ----------------------------------------------------------------------------
module pssc_back #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16,
  parameter int CW = $clog2(MAX_POINTS + 1),
  parameter int AW = $clog2(MAX_POINTS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [pssc_pkg::TolW-1:0]    tol,
  input  logic                         cmd_valid,
  input  pssc_pkg::stroke_cmd_t        cmd,
  input  logic [CW-1:0]                cmd_count,
  output logic                         cmd_pop,
  output logic                         scan_busy,
  output logic                         rd_en,
  output logic [AW-1:0]                rd_addr,
  input  logic signed [COORD_BITS-1:0] rd_x,
  input  logic signed [COORD_BITS-1:0] rd_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output pssc_pkg::shape_out_t         out_data
);

  localparam int DW = COORD_BITS + 1;
  localparam int LW = 2 * DW + 1;
  localparam int PW = 2 * DW + 1;
  localparam int TW = LW + pssc_pkg::TolW;
  localparam int EW = TW + 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_START = 8'b00000010,
    S_END   = 8'b00000100,
    S_LEN   = 8'b00001000,
    S_SCAN  = 8'b00010000,
    S_TEST  = 8'b00100000,
    S_ELL   = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state;
  pssc_pkg::stroke_cmd_t c;
  logic [CW-1:0] n;
  logic [CW-1:0] idx;
  logic issued, pend, scored;
  logic signed [COORD_BITS-1:0] sx, sy, ex, ey;
  logic signed [DW-1:0] dx, dy, qx, qy;
  logic [LW-1:0] len2;
  logic [PW-1:0] peak;
  logic signed [PW:0] c1, c2;
  logic [PW-1:0] absc;
  logic signed [DW-1:0] wv, hv, mv;
  logic [TW-1:0] rhs;
  logic [EW-1:0] g25, m2;
  logic [1:0] kind;
  pssc_pkg::shape_out_t res;

  assign cmd_pop = state == S_IDLE && cmd_valid && !out_valid;
  assign scan_busy = state == S_START || state == S_END || state == S_LEN ||
                     state == S_SCAN;
  assign rd_en = state == S_START || state == S_END || state == S_SCAN;
  assign rd_addr = state == S_START ? '0 :
                   state == S_END ? AW'(n - CW'(1)) : idx[AW-1:0];
  assign absc = (c1 - c2) < 0 ? PW'(c2 - c1) : PW'(c1 - c2);
  assign wv = DW'(c.box_r) - DW'(c.box_l);
  assign hv = DW'(c.box_b) - DW'(c.box_t);
  assign mv = wv > hv ? wv : hv;

  always_comb begin
    res = '0;
    res.shape_kind = kind;
    res.buffer_overflow = c.overflow;
    if (!c.overflow && !c.short_stroke) begin
      res.box_left = c.box_l;
      res.box_top = c.box_t;
      res.box_right = c.box_r;
      res.box_bottom = c.box_b;
      if (kind == pssc_pkg::SHAPE_LINE) begin
        res.line_start_x = sx;
        res.line_start_y = sy;
        res.line_end_x = ex;
        res.line_end_y = ey;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            c <= cmd; n <= cmd_count;
            if (cmd.overflow || cmd.short_stroke) begin
              kind <= pssc_pkg::SHAPE_NONE;
              state <= S_OUT;
            end else begin
              state <= S_START;
            end
          end
        end
        S_START: state <= S_END;
        S_END: begin
          sx <= rd_x; sy <= rd_y;
          state <= S_LEN;
        end
        S_LEN: begin
          ex <= rd_x; ey <= rd_y;
          dx <= DW'(rd_x) - DW'(sx);
          dy <= DW'(rd_y) - DW'(sy);
          if (DW'(rd_x) - DW'(sx) == '0 && DW'(rd_y) - DW'(sy) == '0) begin
            len2 <= '0;
          end
          idx <= '0; issued <= 1'b0; pend <= 1'b0; scored <= 1'b0;
          peak <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          // Length is squared during the scan; products are registered.
          len2 <= LW'(dx * dx) + LW'(dy * dy);
          if (pend) begin
            qx <= DW'(rd_x) - DW'(sx);
            qy <= DW'(rd_y) - DW'(sy);
          end
          c1 <= (PW+1)'(dy * qx);
          c2 <= (PW+1)'(dx * qy);
          if (scored && absc > peak) peak <= absc;
          scored <= issued;
          issued <= pend;
          pend <= idx < n;
          if (idx < n) idx <= idx + CW'(1);
          if (!pend && !issued && !scored && idx == n) state <= S_TEST;
        end
        S_TEST: begin
          rhs <= TW'(len2) * TW'(tol);
          g25 <= EW'(len2) * EW'(25);
          m2 <= EW'(mv * mv);
          state <= S_ELL;
        end
        S_ELL: begin
          if (len2 >= LW'(256) && ({peak, 16'd0} < (PW+16)'(rhs)))
            kind <= pssc_pkg::SHAPE_LINE;
          else if (g25 < m2) kind <= pssc_pkg::SHAPE_ELLIPSE;
          else kind <= pssc_pkg::SHAPE_NONE;
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          out_data <= res;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
